### src/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GCD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gcd assertion failed");

// next-cycle implication
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gcd assertion failed");

`endif

### src/gcd_pkg.sv
package gcd_pkg;

    // fixed-point scale of the angle inputs
    localparam int ANGLE_FRAC_BITS = 23;

    // Q62 constants
    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_Q62    = 64'h2000_0000_0000_0000;
    localparam logic [63:0] PI_Q62      = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // angle range constants in input units
    localparam logic [33:0] ANG_FULL   = 34'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [33:0] ANG_HALF   = 34'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [33:0] ANG_QUART  = 34'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [33:0] ANG_3QUART = 34'(64'd270 << ANGLE_FRAC_BITS);
    localparam logic [29:0] ANG_OCT    = 30'(64'd45 << ANGLE_FRAC_BITS);
    localparam logic [29:0] ANG_QUART30 = 30'(64'd90 << ANGLE_FRAC_BITS);

    // degrees-to-radians factor, Q62 per input lsb
    localparam logic [63:0] HALF_DEG64 = 64'd180 << ANGLE_FRAC_BITS;
    localparam logic [63:0] K_RAD = (PI_Q62 + HALF_DEG64 / 64'd2) / HALF_DEG64;

    // output saturation
    localparam logic [32:0] DIST_MAX = '1;
    localparam logic [23:0] RADIUS_RESET = 24'd6366707;

    // series lengths and pipeline latencies
    localparam int TRIG_TERMS = 10;
    localparam int ASIN_TERMS = 32;
    localparam int SQRT_STEPS = 64;
    localparam int MUL_LAT    = 2;
    localparam int HORNER_LAT = 6;
    localparam int PIPE_LAT   = 4 + 3 * MUL_LAT + TRIG_TERMS * HORNER_LAT + 1
                              + 2 * MUL_LAT + 1 + 1 + SQRT_STEPS + 1
                              + MUL_LAT + ASIN_TERMS * HORNER_LAT + MUL_LAT + 1
                              + MUL_LAT + 1;

    // per-cell series coefficient
    typedef struct packed {
        logic [63:0] recip;
        logic [12:0] den;
        logic [11:0] num;
        logic        add;
    } t_coef;

    // square root recurrence state
    typedef struct packed {
        logic [65:0]  rem;
        logic [63:0]  root;
        logic [127:0] rad;
    } t_sqrt;

    // quadrant and fold flags of one angle lane
    typedef struct packed {
        logic [1:0] quad;
        logic       fold;
    } t_quad;

    // flags travelling beside the root chain
    typedef struct packed {
        logic        neg;
        logic        small_arg;
        logic [63:0] mag;
    } t_acos_side;

    function automatic logic [63:0] neg64(input logic [63:0] v);
        return ~v + 64'd1;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // one step of the modulo-360 reduction
    function automatic logic signed [33:0] ang_wrap(input logic signed [33:0] a);
        logic signed [33:0] full_s;
        full_s = signed'(ANG_FULL);
        if (a < 0) begin
            return a + full_s;
        end else if (a >= full_s) begin
            return a - full_s;
        end
        return a;
    endfunction

endpackage

### src/gcd_mul128.sv
module gcd_mul128 (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);
    import gcd_pkg::*;

    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic [127:0] r_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= i_a[31:0] * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_hh <= i_a[63:32] * i_b[63:32];
        end
    end

    // partial product sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= {r_hh, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0};
        end
    end

    assign o_p = r_p;
endmodule

### src/gcd_horner_cell.sv
module gcd_horner_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  gcd_pkg::t_coef i_coef,
    input  logic [63:0]    i_x2,
    input  logic [63:0]    i_t,
    output logic [63:0]    o_x2,
    output logic [63:0]    o_t
);
    import gcd_pkg::*;

    logic [127:0] w_pa;
    logic [127:0] w_pb;
    logic [63:0]  w_v;
    logic [63:0]  w_qe;
    logic [63:0]  w_rem;
    logic [75:0]  w_qn;
    logic [63:0]  n_q;
    logic [63:0]  n_t;
    logic [63:0]  r_q;
    logic [63:0]  r_t;
    logic [63:0]  r_x2_dly [HORNER_LAT];
    logic [63:0]  r_v_dly [MUL_LAT];

    // x2 times running term
    gcd_mul128 u_mul_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_x2),
        .i_b   (i_t),
        .o_p   (w_pa)
    );
    assign w_v = w_pa[125:62];

    // quotient estimate through the reciprocal
    gcd_mul128 u_mul_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_v),
        .i_b   (i_coef.recip),
        .o_p   (w_pb)
    );
    assign w_qe = w_pb[127:64];

    // estimate is at most one low
    always_comb begin
        w_rem = r_v_dly[MUL_LAT-1] - 64'(w_qe * i_coef.den);
        n_q   = w_qe + {63'd0, (w_rem >= {51'd0, i_coef.den})};
    end

    // new term
    always_comb begin
        w_qn = r_q * i_coef.num;
        n_t  = i_coef.add ? (ONE_Q62 + w_qn[63:0]) : (ONE_Q62 - r_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
            r_t <= n_t;
            r_x2_dly[0] <= i_x2;
            for (int k = 1; k < HORNER_LAT; k++) begin
                r_x2_dly[k] <= r_x2_dly[k-1];
            end
            r_v_dly[0] <= w_v;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_v_dly[k] <= r_v_dly[k-1];
            end
        end
    end

    assign o_t  = r_t;
    assign o_x2 = r_x2_dly[HORNER_LAT-1];
endmodule

### src/gcd_sqrt_cell.sv
module gcd_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  gcd_pkg::t_sqrt i_s,
    output gcd_pkg::t_sqrt o_s
);
    import gcd_pkg::*;

    logic [67:0] w_sh;
    logic [67:0] w_trial;
    t_sqrt       n_s;
    t_sqrt       r_s;

    // one root bit per cell
    always_comb begin
        w_sh    = {i_s.rem, i_s.rad[127:126]};
        w_trial = {2'd0, i_s.root, 2'b01};
        n_s.rad = {i_s.rad[125:0], 2'b00};
        if (w_sh >= w_trial) begin
            n_s.rem  = 66'(w_sh - w_trial);
            n_s.root = {i_s.root[62:0], 1'b1};
        end else begin
            n_s.rem  = w_sh[65:0];
            n_s.root = {i_s.root[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;
endmodule

### src/great_circle_distance_unit.sv
// Great-circle distance by the spherical law of cosines. Each request carries two points
// (latitude and longitude in degrees with 23 fraction bits); the result is the central
// angle times the configured sphere radius, in meters with 8 fraction bits, saturating at
// the top of the field. The datapath is a fully pipelined row of cells: sine and cosine by
// ten Horner cells per series, a 64-cell bit-serial square root and 32 arcsine cells. A new
// request is taken every cycle while the result side does not hold the pipeline. The radius
// may be written only while no request is in flight; the write port is always ready. A stall
// on the result side while a result is offered freezes the pipeline.
module great_circle_distance_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_lat_a,
    input  logic [31:0] i_lon_a,
    input  logic [30:0] i_lat_b,
    input  logic [31:0] i_lon_b,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [32:0] o_dist_m,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_sphere_radius_m
);
    import gcd_pkg::*;

    localparam int QF_DLY = 3 * MUL_LAT + TRIG_TERMS * HORNER_LAT;
    localparam int X_DLY  = MUL_LAT + TRIG_TERMS * HORNER_LAT;
    localparam int S_DLY  = MUL_LAT + ASIN_TERMS * HORNER_LAT;
    localparam int F_DLY  = 2 * MUL_LAT + ASIN_TERMS * HORNER_LAT;

    logic                en;
    logic [PIPE_LAT-1:0] r_vld;
    logic [23:0]         r_radius;

    logic signed [33:0]  r_ang1 [3];
    logic signed [33:0]  r_ang2 [3];
    logic signed [33:0]  r_ang3 [3];
    t_quad               n_qf [3];
    logic [29:0]         n_xin [3];
    t_quad               r_qf [3];
    logic [29:0]         r_xin [3];
    t_quad               r_qf_dly [QF_DLY][3];
    logic [63:0]         r_x_dly [X_DLY][3];
    logic [63:0]         r_tc_dly [MUL_LAT][3];

    logic [127:0]        w_kp [3];
    logic [127:0]        w_x2p [3];
    logic [127:0]        w_sfp [3];
    logic [63:0]         w_st [3][TRIG_TERMS+1];
    logic [63:0]         w_sx2 [3][TRIG_TERMS+1];
    logic [63:0]         w_ct [3][TRIG_TERMS+1];
    logic [63:0]         w_cx2 [3][TRIG_TERMS+1];

    logic [63:0]         n_sn [3];
    logic [63:0]         n_cs [3];
    logic [63:0]         r_sn [3];
    logic [63:0]         r_cs [3];

    logic [127:0]        w_p1p;
    logic [127:0]        w_ccp;
    logic [127:0]        w_p2p;
    logic                r_p1s_dly [MUL_LAT];
    logic                r_ccs_dly [MUL_LAT];
    logic [63:0]         r_cd_dly [MUL_LAT];
    logic [63:0]         r_p1_dly [MUL_LAT];
    logic                r_p2s_dly [MUL_LAT];
    logic [63:0]         w_p1v;
    logic [63:0]         w_p2v;
    logic signed [64:0]  w_sum;
    logic [63:0]         n_c;
    logic [63:0]         r_c;

    logic [63:0]         w_cm;
    t_sqrt               r_sq0;
    t_acos_side          r_side0;
    t_acos_side          r_side_dly [SQRT_STEPS];
    t_sqrt               w_sq [SQRT_STEPS+1];

    logic [63:0]         r_s;
    logic                r_sel_neg;
    logic                r_sel_small;
    logic [63:0]         r_s_dly [S_DLY];
    logic                r_fneg_dly [F_DLY];
    logic                r_fsmall_dly [F_DLY];
    logic [127:0]        w_s2p;
    logic [63:0]         w_at [ASIN_TERMS+1];
    logic [63:0]         w_ax2 [ASIN_TERMS+1];
    logic [127:0]        w_afp;
    logic [63:0]         w_asin;
    logic [63:0]         w_a;
    logic [63:0]         n_theta;
    logic [63:0]         r_theta;
    logic [127:0]        w_tp;
    logic [88:0]         w_rnd;
    logic [34:0]         w_res;
    logic [32:0]         n_dist;
    logic [32:0]         r_dist;

    // pipeline advance and handshakes
    assign en          = !(r_vld[PIPE_LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[PIPE_LAT-1];
    assign o_dist_m    = r_dist;
    assign o_cfg_ready = 1'b1;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radius <= i_sphere_radius_m;
        end
    end

    // input capture and two wrap steps
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang1[0] <= {{3{i_lat_a[30]}}, i_lat_a};
            r_ang1[1] <= {{3{i_lat_b[30]}}, i_lat_b};
            r_ang1[2] <= {{2{i_lon_a[31]}}, i_lon_a} - {{2{i_lon_b[31]}}, i_lon_b};
            for (int l = 0; l < 3; l++) begin
                r_ang2[l] <= ang_wrap(r_ang1[l]);
                r_ang3[l] <= ang_wrap(r_ang2[l]);
            end
        end
    end

    // quadrant split and fold to the first octant
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [33:0] r;
            logic [29:0] rr;
            r = r_ang3[l];
            if (r < ANG_QUART) begin
                n_qf[l].quad = 2'd0;
                rr = r[29:0];
            end else if (r < ANG_HALF) begin
                n_qf[l].quad = 2'd1;
                rr = 30'(r - ANG_QUART);
            end else if (r < ANG_3QUART) begin
                n_qf[l].quad = 2'd2;
                rr = 30'(r - ANG_HALF);
            end else begin
                n_qf[l].quad = 2'd3;
                rr = 30'(r - ANG_3QUART);
            end
            n_qf[l].fold = rr > ANG_OCT;
            n_xin[l] = n_qf[l].fold ? (ANG_QUART30 - rr) : rr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_qf[l]  <= n_qf[l];
                r_xin[l] <= n_xin[l];
            end
        end
    end

    // sine and cosine lanes: latitude a, latitude b, longitude difference
    for (genvar l = 0; l < 3; l++) begin : g_lane
        gcd_mul128 u_mul_k (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   ({34'd0, r_xin[l]}),
            .i_b   (K_RAD),
            .o_p   (w_kp[l])
        );

        gcd_mul128 u_mul_x2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (w_kp[l][63:0]),
            .i_b   (w_kp[l][63:0]),
            .o_p   (w_x2p[l])
        );

        assign w_st[l][0]  = ONE_Q62;
        assign w_ct[l][0]  = ONE_Q62;
        assign w_sx2[l][0] = w_x2p[l][125:62];
        assign w_cx2[l][0] = w_x2p[l][125:62];

        for (genvar i = 0; i < TRIG_TERMS; i++) begin : g_term
            localparam int unsigned NN = TRIG_TERMS - i;
            localparam int unsigned DS = (2 * NN) * (2 * NN + 1);
            localparam int unsigned DC = (2 * NN - 1) * (2 * NN);
            localparam logic [64:0] RS = (65'd1 << 64) / 65'(DS);
            localparam logic [64:0] RC = (65'd1 << 64) / 65'(DC);
            localparam t_coef CS = '{recip: RS[63:0], den: 13'(DS), num: 12'd1, add: 1'b0};
            localparam t_coef CC = '{recip: RC[63:0], den: 13'(DC), num: 12'd1, add: 1'b0};

            gcd_horner_cell u_sin (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_coef (CS),
                .i_x2   (w_sx2[l][i]),
                .i_t    (w_st[l][i]),
                .o_x2   (w_sx2[l][i+1]),
                .o_t    (w_st[l][i+1])
            );

            gcd_horner_cell u_cos (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_coef (CC),
                .i_x2   (w_cx2[l][i]),
                .i_t    (w_ct[l][i]),
                .o_x2   (w_cx2[l][i+1]),
                .o_t    (w_ct[l][i+1])
            );
        end

        gcd_mul128 u_mul_sf (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_x_dly[X_DLY-1][l]),
            .i_b   (w_st[l][TRIG_TERMS]),
            .o_p   (w_sfp[l])
        );
    end

    // lane side delays
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_qf_dly[0][l] <= r_qf[l];
                for (int k = 1; k < QF_DLY; k++) begin
                    r_qf_dly[k][l] <= r_qf_dly[k-1][l];
                end
                r_x_dly[0][l] <= w_kp[l][63:0];
                for (int k = 1; k < X_DLY; k++) begin
                    r_x_dly[k][l] <= r_x_dly[k-1][l];
                end
                r_tc_dly[0][l] <= w_ct[l][TRIG_TERMS];
                for (int k = 1; k < MUL_LAT; k++) begin
                    r_tc_dly[k][l] <= r_tc_dly[k-1][l];
                end
            end
        end
    end

    // unfold and place in quadrant
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [63:0] s;
            logic [63:0] c;
            t_quad       qf;
            qf = r_qf_dly[QF_DLY-1][l];
            if (qf.fold) begin
                s = r_tc_dly[MUL_LAT-1][l];
                c = w_sfp[l][125:62];
            end else begin
                s = w_sfp[l][125:62];
                c = r_tc_dly[MUL_LAT-1][l];
            end
            case (qf.quad)
                2'd0: begin
                    n_sn[l] = s;
                    n_cs[l] = c;
                end
                2'd1: begin
                    n_sn[l] = c;
                    n_cs[l] = neg64(s);
                end
                2'd2: begin
                    n_sn[l] = neg64(s);
                    n_cs[l] = neg64(c);
                end
                default: begin
                    n_sn[l] = neg64(c);
                    n_cs[l] = s;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_sn[l] <= n_sn[l];
                r_cs[l] <= n_cs[l];
            end
        end
    end

    // sin a sin b and cos a cos b cos dlon
    gcd_mul128 u_mul_p1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (mag64(r_sn[0])),
        .i_b   (mag64(r_sn[1])),
        .o_p   (w_p1p)
    );

    gcd_mul128 u_mul_cc (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (mag64(r_cs[0])),
        .i_b   (mag64(r_cs[1])),
        .o_p   (w_ccp)
    );

    gcd_mul128 u_mul_p2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (w_ccp[125:62]),
        .i_b   (mag64(r_cd_dly[MUL_LAT-1])),
        .o_p   (w_p2p)
    );

    assign w_p1v = r_p1s_dly[MUL_LAT-1] ? neg64(w_p1p[125:62]) : w_p1p[125:62];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1s_dly[0] <= r_sn[0][63] ^ r_sn[1][63];
            r_ccs_dly[0] <= r_cs[0][63] ^ r_cs[1][63];
            r_cd_dly[0]  <= r_cs[2];
            r_p1_dly[0]  <= w_p1v;
            r_p2s_dly[0] <= r_ccs_dly[MUL_LAT-1] ^ r_cd_dly[MUL_LAT-1][63];
            for (int k = 1; k < MUL_LAT; k++) begin
                r_p1s_dly[k] <= r_p1s_dly[k-1];
                r_ccs_dly[k] <= r_ccs_dly[k-1];
                r_cd_dly[k]  <= r_cd_dly[k-1];
                r_p1_dly[k]  <= r_p1_dly[k-1];
                r_p2s_dly[k] <= r_p2s_dly[k-1];
            end
        end
    end

    // sum and clamp to [-1, 1]
    always_comb begin
        w_p2v = r_p2s_dly[MUL_LAT-1] ? neg64(w_p2p[125:62]) : w_p2p[125:62];
        w_sum = signed'({r_p1_dly[MUL_LAT-1][63], r_p1_dly[MUL_LAT-1]})
              + signed'({w_p2v[63], w_p2v});
        if (w_sum > signed'({1'b0, ONE_Q62})) begin
            n_c = ONE_Q62;
        end else if (w_sum < -signed'({1'b0, ONE_Q62})) begin
            n_c = neg64(ONE_Q62);
        end else begin
            n_c = w_sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c <= n_c;
        end
    end

    // root argument (1 - |c|) / 2 scaled for the bit-serial root
    assign w_cm = mag64(r_c);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0.neg       <= r_c[63];
            r_side0.small_arg <= w_cm <= HALF_Q62;
            r_side0.mag       <= w_cm;
            r_sq0.rem         <= '0;
            r_sq0.root        <= '0;
            r_sq0.rad         <= {3'd0, ONE_Q62 - w_cm, 61'd0};
        end
    end

    // square root chain
    assign w_sq[0] = r_sq0;
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        gcd_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_s   (w_sq[i]),
            .o_s   (w_sq[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_dly[0] <= r_side0;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    // arcsine argument select
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s         <= r_side_dly[SQRT_STEPS-1].small_arg ? r_side_dly[SQRT_STEPS-1].mag
                                                              : w_sq[SQRT_STEPS].root;
            r_sel_neg   <= r_side_dly[SQRT_STEPS-1].neg;
            r_sel_small <= r_side_dly[SQRT_STEPS-1].small_arg;
        end
    end

    // arcsine series chain
    gcd_mul128 u_mul_s2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s),
        .i_b   (r_s),
        .o_p   (w_s2p)
    );

    assign w_at[0]  = ONE_Q62;
    assign w_ax2[0] = w_s2p[125:62];

    for (genvar i = 0; i < ASIN_TERMS; i++) begin : g_asin
        localparam int unsigned NN = ASIN_TERMS - i;
        localparam int unsigned DA = (2 * NN) * (2 * NN + 1);
        localparam int unsigned NA = (2 * NN - 1) * (2 * NN - 1);
        localparam logic [64:0] RA = (65'd1 << 64) / 65'(DA);
        localparam t_coef CA = '{recip: RA[63:0], den: 13'(DA), num: 12'(NA), add: 1'b1};

        gcd_horner_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_coef (CA),
            .i_x2   (w_ax2[i]),
            .i_t    (w_at[i]),
            .o_x2   (w_ax2[i+1]),
            .o_t    (w_at[i+1])
        );
    end

    gcd_mul128 u_mul_af (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s_dly[S_DLY-1]),
        .i_b   (w_at[ASIN_TERMS]),
        .o_p   (w_afp)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_dly[0]      <= r_s;
            r_fneg_dly[0]   <= r_sel_neg;
            r_fsmall_dly[0] <= r_sel_small;
            for (int k = 1; k < S_DLY; k++) begin
                r_s_dly[k] <= r_s_dly[k-1];
            end
            for (int k = 1; k < F_DLY; k++) begin
                r_fneg_dly[k]   <= r_fneg_dly[k-1];
                r_fsmall_dly[k] <= r_fsmall_dly[k-1];
            end
        end
    end

    // central angle
    always_comb begin
        w_asin = w_afp[125:62];
        w_a    = r_fsmall_dly[F_DLY-1] ? w_asin : {w_asin[62:0], 1'b0};
        if (r_fsmall_dly[F_DLY-1]) begin
            n_theta = r_fneg_dly[F_DLY-1] ? (HALF_PI_Q62 + w_a) : (HALF_PI_Q62 - w_a);
        end else begin
            n_theta = r_fneg_dly[F_DLY-1] ? (PI_Q62 - w_a) : w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= n_theta;
        end
    end

    // scale by radius, round and saturate
    gcd_mul128 u_mul_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_theta),
        .i_b   ({40'd0, r_radius}),
        .o_p   (w_tp)
    );

    always_comb begin
        w_rnd  = w_tp[88:0] + (89'd1 << 53);
        w_res  = w_rnd[88:54];
        n_dist = (w_res > {2'd0, DIST_MAX}) ? DIST_MAX : w_res[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= n_dist;
        end
    end
endmodule

### src/gcd_checker.sv
`include "assert_macros.svh"

module gcd_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [32:0] o_dist_m,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);
    // a stalled result stays offered
    `GCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its value
    `GCD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_dist_m))

    // input side only backs up behind a held result
    `GCD_ASSERT_NOW(a_in_stall_src, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // radius writes are never refused
    `GCD_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)
endmodule

bind great_circle_distance_unit gcd_port_checker u_gcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_dist_m    (o_dist_m),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

### tb/gcd_checker.sv
`timescale 1ns / 100ps

module gcd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [30:0] i_lat_a,
    input  logic [31:0] i_lon_a,
    input  logic [30:0] i_lat_b,
    input  logic [31:0] i_lon_b,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [32:0] i_dist_m,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [23:0] i_sphere_radius_m,
    output int          o_fail_count,
    output int          o_pending
);
    import gcd_pkg::*;

    logic [23:0] radius_m;
    logic [32:0] dist_expected[$];

    // truncating Q62 product of two unsigned magnitudes
    function automatic logic [63:0] q62_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    // signed Q62 product, sign applied to the truncated magnitude
    function automatic longint q62_smul(input longint x, input longint y);
        logic        neg;
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] m;
        neg = (x < 0) != (y < 0);
        mx  = x < 0 ? 64'd0 - 64'(x) : 64'(x);
        my  = y < 0 ? 64'd0 - 64'(y) : 64'(y);
        m   = q62_mul(mx, my);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // horner taylor series for sine and cosine, x in [0, pi/4]
    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = q62_mul(x, x);
        t  = ONE_Q62;
        for (int n = 10; n >= 1; n--) begin
            t = ONE_Q62 - q62_mul(x2, t) / 64'((2 * n) * (2 * n + 1));
        end
        return q62_mul(x, t);
    endfunction

    function automatic logic [63:0] taylor_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = q62_mul(x, x);
        t  = ONE_Q62;
        for (int n = 10; n >= 1; n--) begin
            t = ONE_Q62 - q62_mul(x2, t) / 64'((2 * n - 1) * (2 * n));
        end
        return t;
    endfunction

    // reduce an angle to one octant, evaluate, and unfold by quadrant
    function automatic void angle_trig(input longint ang, output longint sn,
                                       output longint cs);
        longint      full;
        longint      quart;
        longint      oct;
        longint      r;
        longint      rr;
        longint      s;
        longint      c;
        logic [63:0] k;
        logic [63:0] x;
        int          quad;
        full  = longint'(360) <<< ANGLE_FRAC_BITS;
        quart = longint'(90) <<< ANGLE_FRAC_BITS;
        oct   = longint'(45) <<< ANGLE_FRAC_BITS;
        k     = (PI_Q62 + (64'd180 << ANGLE_FRAC_BITS) / 2) / (64'd180 << ANGLE_FRAC_BITS);
        r     = ang % full;
        if (r < 0) begin
            r = r + full;
        end
        quad = int'(r / quart);
        rr   = r % quart;
        if (rr <= oct) begin
            x = 64'(rr) * k;
            s = $signed(taylor_sin(x));
            c = $signed(taylor_cos(x));
        end else begin
            x = 64'(quart - rr) * k;
            s = $signed(taylor_cos(x));
            c = $signed(taylor_sin(x));
        end
        case (quad & 3)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    // arcsine series for arguments up to one half
    function automatic logic [63:0] asin_series(input logic [63:0] s);
        logic [63:0] s2;
        logic [63:0] t;
        s2 = q62_mul(s, s);
        t  = ONE_Q62;
        for (int n = 32; n >= 1; n--) begin
            t = ONE_Q62 + (q62_mul(s2, t) / 64'((2 * n) * (2 * n + 1)))
                * 64'((2 * n - 1) * (2 * n - 1));
        end
        return q62_mul(s, t);
    endfunction

    // floor square root of a 128-bit radicand
    function automatic logic [63:0] floor_sqrt(input logic [127:0] rad);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= rad) begin
                root = cand;
            end
        end
        return root;
    endfunction

    // central angle from the clamped cosine
    function automatic logic [63:0] central_angle(input longint c);
        logic        neg;
        logic [63:0] m;
        logic [63:0] d;
        logic [63:0] a;
        neg = c < 0;
        m   = neg ? 64'd0 - 64'(c) : 64'(c);
        if (m <= ONE_Q62 / 2) begin
            a = asin_series(m);
            return neg ? HALF_PI_Q62 + a : HALF_PI_Q62 - a;
        end
        d = ONE_Q62 - m;
        a = 2 * asin_series(floor_sqrt({64'd0, d} << 61));
        return neg ? PI_Q62 - a : a;
    endfunction

    // expected distance of one point pair at the current radius
    function automatic logic [32:0] predict_distance(input logic [30:0] lat_a,
                                                     input logic [31:0] lon_a,
                                                     input logic [30:0] lat_b,
                                                     input logic [31:0] lon_b,
                                                     input logic [23:0] radius);
        longint       la;
        longint       oa;
        longint       lb;
        longint       ob;
        longint       sa;
        longint       ca;
        longint       sb;
        longint       cb;
        longint       sd;
        longint       cd;
        longint       p1;
        longint       p2;
        longint       cos_c;
        logic [63:0]  u;
        logic [63:0]  theta;
        logic [127:0] prod;
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [63:0]  lo2;
        logic [63:0]  res;
        la = $signed(lat_a);
        oa = $signed(lon_a);
        lb = $signed(lat_b);
        ob = $signed(lon_b);
        angle_trig(la, sa, ca);
        angle_trig(lb, sb, cb);
        angle_trig(oa - ob, sd, cd);
        p1 = q62_smul(sa, sb);
        p2 = q62_smul(q62_smul(ca, cb), cd);
        if (p1 > 0 && p2 > 0) begin
            u     = 64'(p1) + 64'(p2);
            cos_c = u > ONE_Q62 ? $signed(ONE_Q62) : $signed(u);
        end else begin
            cos_c = p1 + p2;
        end
        if (cos_c > $signed(ONE_Q62)) begin
            cos_c = $signed(ONE_Q62);
        end
        if (cos_c < -$signed(ONE_Q62)) begin
            cos_c = -$signed(ONE_Q62);
        end
        theta = central_angle(cos_c);
        prod  = {64'd0, theta} * {104'd0, radius};
        hi    = prod[127:64];
        lo    = prod[63:0];
        lo2   = lo + (64'd1 << 53);
        if (lo2 < lo) begin
            hi = hi + 1;
        end
        res = (hi << 10) | (lo2 >> 54);
        if (res > 64'(DIST_MAX)) begin
            res = 64'(DIST_MAX);
        end
        return res[32:0];
    endfunction

    // track the radius, queue predictions, compare results in order
    always @(posedge i_clk) begin
        logic [32:0] want;
        if (!i_rst_n) begin
            radius_m     <= RADIUS_RESET;
            o_fail_count <= 0;
            dist_expected.delete();
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                radius_m <= i_sphere_radius_m;
            end
            if (i_in_valid && !i_in_stall) begin
                dist_expected.push_back(predict_distance(i_lat_a, i_lon_a, i_lat_b,
                                                         i_lon_b, radius_m));
            end
            if (i_out_valid && !i_out_stall) begin
                if (dist_expected.size() == 0) begin
                    $display("%0t: unexpected result dist_m=%0d", $time, i_dist_m);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = dist_expected.pop_front();
                    if (want !== i_dist_m) begin
                        $display("%0t: dist_m expected %0d actual %0d", $time, want,
                                 i_dist_m);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= dist_expected.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import gcd_pkg::*;

    localparam longint LAT_MAX = 754974720;
    localparam longint LON_MAX = 1509949440;
    localparam longint DEG180  = longint'(180) <<< ANGLE_FRAC_BITS;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [30:0] lat_a = '0;
    logic [31:0] lon_a = '0;
    logic [30:0] lat_b = '0;
    logic [31:0] lon_b = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [32:0] dist_m;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_radius = '0;
    int          fail_count;
    int          pending;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    logic        long_hold_done = 1'b0;
    logic [23:0] radius_plan[6];

    great_circle_distance_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_lat_a          (lat_a),
        .i_lon_a          (lon_a),
        .i_lat_b          (lat_b),
        .i_lon_b          (lon_b),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_dist_m         (dist_m),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_sphere_radius_m(cfg_radius)
    );

    gcd_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_lat_a          (lat_a),
        .i_lon_a          (lon_a),
        .i_lat_b          (lat_b),
        .i_lon_b          (lon_b),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_dist_m         (dist_m),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_sphere_radius_m(cfg_radius),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random gap length, mostly short with a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // result side: random stalls, calm stretches and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!long_hold_done && results_seen >= 150) begin
            long_hold_done <= 1'b1;
            stall_left     <= 800;
            out_stall      <= 1'b1;
        end else if ((results_seen / 200) % 2 == 1) begin
            out_stall <= 1'b0;
        end else begin
            int g;
            g = gap_length();
            out_stall  <= g != 0;
            stall_left <= g > 1 ? g - 1 : 0;
        end
    end

    // count accepted results and watch for a hung block
    always @(posedge i_clk) begin
        if (out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
        end
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("great_circle_distance_unit: mismatch");
                $finish;
            end
        end
    end

    // offer one request and hold it until it is taken
    task automatic send_pair(input longint la, input longint oa, input longint lb,
                             input longint ob);
        int g;
        g = (requests_sent / 150) % 3 == 2 ? 0 : gap_length();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        lat_a    <= 31'(la);
        lon_a    <= 32'(oa);
        lat_b    <= 31'(lb);
        lon_b    <= 32'(ob);
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // write the radius once the pipeline has drained
    task automatic write_radius(input logic [23:0] radius);
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_valid  <= 1'b1;
        cfg_radius <= radius;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint span(input longint lim);
        return longint'($urandom_range(32'(2 * lim))) - lim;
    endfunction

    // random pair: uniform, nearby, near antipodal, raw bits or special points
    task automatic send_random_pair();
        longint la, oa, lb, ob, d;
        int     mode;
        mode = $urandom_range(99);
        la = span(LAT_MAX);
        oa = span(LON_MAX);
        lb = span(LAT_MAX);
        ob = span(LON_MAX);
        d  = longint'(1) <<< $urandom_range(0, 24);
        if (mode < 55) begin
        end else if (mode < 72) begin
            lb = la + span(d);
            ob = oa + span(d);
        end else if (mode < 82) begin
            lb = -la + span(d);
            ob = (oa >= 0 ? oa - DEG180 : oa + DEG180) + span(d);
        end else if (mode < 94) begin
            la = $signed(31'($urandom));
            oa = $signed(32'($urandom));
            lb = $signed(31'($urandom));
            ob = $signed(32'($urandom));
        end else begin
            la = $urandom_range(1) ? LAT_MAX : -LAT_MAX;
            lb = $urandom_range(2) == 0 ? la : span(LAT_MAX);
            oa = $urandom_range(1) ? LON_MAX : -LON_MAX;
        end
        send_pair(la, oa, lb, ob);
    endtask

    initial begin
        radius_plan = '{RADIUS_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'($urandom),
                        24'($urandom_range(6000000, 6400000))};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: same point, antipodes, poles, field extremes, wrap cases
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 0, DEG180);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(LAT_MAX, 12345, LAT_MAX, -98765);
        send_pair(100, 200, 100, 201);
        send_pair(0, 0, 1, 0);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(0, DEG180, 0, -DEG180);
        send_pair(-(longint'(1) <<< 30), 0, (longint'(1) <<< 30) - 1, 0);
        send_pair((longint'(1) <<< 30) - 1, -(longint'(1) <<< 31), 0, (longint'(1) <<< 31) - 1);
        send_pair(LAT_MAX / 3, 0, LAT_MAX / 3, DEG180 / 2);
        send_pair(-LAT_MAX / 2, DEG180 / 4, LAT_MAX / 2, -DEG180 * 3 / 4);
        send_pair(400000000, 900000000, -400000000, 900000000 - DEG180 + 7);
        send_pair(LAT_MAX / 2, 0, LAT_MAX / 2, DEG180 * 2 / 3);
        send_pair(-1, -1, -1, -1);

        // phases through several radius settings
        foreach (radius_plan[p]) begin
            if (p != 0) begin
                write_radius(radius_plan[p]);
            end
            if (p == 2) begin
                send_pair(0, 0, 0, DEG180);
                send_pair(LAT_MAX, 0, -LAT_MAX, 0);
            end
            repeat (188) send_random_pair();
        end
        in_valid <= 1'b0;

        // drain and give the verdict
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("great_circle_distance_unit: match");
        end else begin
            $display("great_circle_distance_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/gcd_pkg.sv
src/gcd_mul128.sv
src/gcd_horner_cell.sv
src/gcd_sqrt_cell.sv
src/great_circle_distance_unit.sv
src/gcd_checker.sv
tb/gcd_checker.sv
tb/tb.sv
